@@ rtl/core/mcta_pkg.sv @@
package mcta_pkg;

   localparam int CMD_W   = 3;
   localparam int ADDR_W  = 32;
   localparam int STATE_W = 2;
   localparam int LOC_W   = 9;
   localparam int VACT_W  = 2;

   localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_STORE  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_PROBE  = 3'd4;

   localparam logic [STATE_W-1:0] MESI_I = 2'd0;
   localparam logic [STATE_W-1:0] MESI_S = 2'd1;
   localparam logic [STATE_W-1:0] MESI_E = 2'd2;
   localparam logic [STATE_W-1:0] MESI_M = 2'd3;

   localparam logic [VACT_W-1:0] VACT_NONE          = 2'd0;
   localparam logic [VACT_W-1:0] VACT_WRITE_BACK    = 2'd1;
   localparam logic [VACT_W-1:0] VACT_WRITE_THROUGH = 2'd2;

   typedef struct packed {
      logic                tag_found;
      logic                hit;
      logic [STATE_W-1:0]  line_state;
      logic [LOC_W-1:0]    line_location;
      logic [VACT_W-1:0]   victim_action;
      logic [ADDR_W-1:0]   evict_addr;
      logic                update_missed;
   } rsp_payload_type;

endpackage

@@ rtl/core/mcta_req_if.sv @@
interface mcta_req_if;
   import mcta_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   cmd;
   logic [ADDR_W-1:0]  address;
   logic [STATE_W-1:0] new_state;

   modport source (output valid, output cmd, output address, output new_state, input ready);
   modport sink (input valid, input cmd, input address, input new_state, output ready);
endinterface

@@ rtl/core/mcta_rsp_if.sv @@
interface mcta_rsp_if;
   import mcta_pkg::*;

   logic               valid;
   logic               ready;
   logic               tag_found;
   logic               hit;
   logic [STATE_W-1:0] line_state;
   logic [LOC_W-1:0]   line_location;
   logic [VACT_W-1:0]  victim_action;
   logic [ADDR_W-1:0]  evict_addr;
   logic               update_missed;

   modport source (output valid, output tag_found, output hit, output line_state,
                   output line_location, output victim_action, output evict_addr,
                   output update_missed, input ready);
   modport sink (input valid, input tag_found, input hit, input line_state,
                 input line_location, input victim_action, input evict_addr,
                 input update_missed, output ready);
endinterface

@@ rtl/core/mesi_cache_tag_array_clock_unit.sv @@
// An accepted item enters lookup with its set row read; its result is then registered
// and the row written back, and no new item is taken until the unit is back in ready.
// The result waits in an output register; while it waits, the next item stays in lookup
// and the input is held off.
// Reset: synchronous, active high; a clearing pass then zeroes each of the SETS set rows
// while no item is accepted. The level register resets to private.
module mesi_cache_tag_array_clock_unit #(
   parameter int SETS       = 64,
   parameter int WAYS       = 8,
   parameter int LINE_BYTES = 64,
   parameter int ADDR_BITS  = 32
) (
   input  logic       clock,
   input  logic       reset,
   mcta_req_if.sink   req_ch,
   mcta_rsp_if.source rsp_ch,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);
   import mcta_pkg::*;

   localparam int EFF_BITS = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam int OFF_LOG  = $clog2(LINE_BYTES + 1) - 1;
   localparam int SET_LOG  = $clog2(SETS + 1) - 1;
   localparam int TAG_RAW  = EFF_BITS - OFF_LOG - SET_LOG;
   localparam int TAG_BITS = (TAG_RAW > 1) ? TAG_RAW : 1;
   localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int HAND_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ROW_BITS = WAYS * (TAG_BITS + STATE_W + 1) + HAND_W;
   localparam logic [ADDR_W-1:0] ADDR_MASK = ADDR_W'((64'd1 << EFF_BITS) - 64'd1);

   typedef enum logic [1:0] {
      CLEARING,
      READY,
      LOOKUP
   } state_type;

   state_type           state_ff;
   logic [SET_W-1:0]    clr_cnt_ff;
   logic                private_level_ff;
   logic [CMD_W-1:0]    cmd_ff;
   logic [SET_W-1:0]    set_ff;
   logic [TAG_BITS-1:0] tag_ff;
   logic [STATE_W-1:0]  nst_ff;
   logic                rsp_valid_ff;
   rsp_payload_type     rsp_ff;

   logic [ADDR_W-1:0]   addr_eff;
   logic [ADDR_W-1:0]   line_num;
   logic [SET_W-1:0]    req_set;
   logic [TAG_BITS-1:0] req_tag;
   logic                accept;
   logic                finish;
   logic [ROW_BITS-1:0] row_rd;
   logic [ROW_BITS-1:0] row_wr;
   logic                row_we;
   logic                ram_we;
   logic [SET_W-1:0]    ram_waddr;
   logic [ROW_BITS-1:0] ram_wdata;
   rsp_payload_type     result;

   assign addr_eff = req_ch.address & ADDR_MASK;
   assign line_num = addr_eff / ADDR_W'(LINE_BYTES);
   assign req_set  = SET_W'(line_num % ADDR_W'(SETS));
   assign req_tag  = TAG_BITS'(line_num / ADDR_W'(SETS));

   assign req_ch.ready = (state_ff == READY);
   assign accept       = req_ch.valid && req_ch.ready;
   assign finish       = (state_ff == LOOKUP) && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = set_ff;
      ram_wdata = row_wr;
      if (state_ff == CLEARING) begin
         ram_we    = 1'b1;
         ram_waddr = clr_cnt_ff;
         ram_wdata = '0;
      end else if (finish && row_we) begin
         ram_we = 1'b1;
      end
   end

   mcta_row_ram #(
      .DEPTH  (SETS),
      .IDX_W  (SET_W),
      .DATA_W (ROW_BITS)
   ) u_row_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (req_set),
      .rd_data (row_rd),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata)
   );

   mcta_way_logic #(
      .SETS       (SETS),
      .WAYS       (WAYS),
      .LINE_BYTES (LINE_BYTES),
      .TAG_BITS   (TAG_BITS),
      .SET_W      (SET_W),
      .HAND_W     (HAND_W),
      .ROW_BITS   (ROW_BITS)
   ) u_way_logic (
      .row_rd        (row_rd),
      .cmd           (cmd_ff),
      .set_idx       (set_ff),
      .tag           (tag_ff),
      .new_state     (nst_ff),
      .private_level (private_level_ff),
      .row_wr        (row_wr),
      .row_we        (row_we),
      .result        (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= CLEARING;
         clr_cnt_ff       <= '0;
         private_level_ff <= 1'b1;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            private_level_ff <= csr_wr_data;
         end
         unique case (state_ff)
            CLEARING: begin
               clr_cnt_ff <= clr_cnt_ff + SET_W'(1);
               if (clr_cnt_ff == SET_W'(SETS - 1)) begin
                  state_ff <= READY;
               end
            end
            READY: begin
               if (accept) begin
                  cmd_ff   <= req_ch.cmd;
                  set_ff   <= req_set;
                  tag_ff   <= req_tag;
                  nst_ff   <= req_ch.new_state;
                  state_ff <= LOOKUP;
               end
            end
            LOOKUP: begin
               if (finish) begin
                  state_ff <= READY;
               end
            end
            default: begin
               state_ff <= CLEARING;
            end
         endcase
         if (finish) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff       <= result;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.tag_found      = rsp_ff.tag_found;
   assign rsp_ch.hit            = rsp_ff.hit;
   assign rsp_ch.line_state     = rsp_ff.line_state;
   assign rsp_ch.line_location  = rsp_ff.line_location;
   assign rsp_ch.victim_action  = rsp_ff.victim_action;
   assign rsp_ch.evict_addr     = rsp_ff.evict_addr;
   assign rsp_ch.update_missed  = rsp_ff.update_missed;

endmodule

@@ rtl/core/mcta_row_ram.sv @@
module mcta_row_ram #(
   parameter int DEPTH  = 64,
   parameter int IDX_W  = 6,
   parameter int DATA_W = 200
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/mcta_way_logic.sv @@
module mcta_way_logic #(
   parameter int SETS       = 64,
   parameter int WAYS       = 8,
   parameter int LINE_BYTES = 64,
   parameter int TAG_BITS   = 20,
   parameter int SET_W      = 6,
   parameter int HAND_W     = 3,
   parameter int ROW_BITS   = 8 * 23 + 3
) (
   input  logic [ROW_BITS-1:0]         row_rd,
   input  logic [mcta_pkg::CMD_W-1:0]   cmd,
   input  logic [SET_W-1:0]            set_idx,
   input  logic [TAG_BITS-1:0]         tag,
   input  logic [mcta_pkg::STATE_W-1:0] new_state,
   input  logic                        private_level,
   output logic [ROW_BITS-1:0]         row_wr,
   output logic                        row_we,
   output mcta_pkg::rsp_payload_type   result
);
   import mcta_pkg::*;

   localparam int LOC_BITS = $clog2(SETS * WAYS + 1);

   typedef struct packed {
      logic [TAG_BITS-1:0] tag;
      logic [STATE_W-1:0]  state;
      logic                use_bit;
   } way_type;

   typedef struct packed {
      way_type [WAYS-1:0] ways;
      logic [HAND_W-1:0]  hand;
   } row_type;

   row_type                old_row;
   row_type                new_row;
   logic                   found;
   logic [HAND_W-1:0]      match_way;
   logic                   any_invalid;
   logic [HAND_W-1:0]      invalid_way;
   logic [HAND_W-1:0]      ring_idx [WAYS];
   logic [HAND_W:0]        ring_sum;
   logic [HAND_W:0]        rank;
   logic                   any_free;
   logic [HAND_W-1:0]      free_rank;
   logic [HAND_W-1:0]      victim;
   logic [HAND_W:0]        next_hand;
   logic [STATE_W-1:0]     line_state;
   logic [STATE_W-1:0]     victim_state;
   logic [LOC_BITS-1:0]    base_loc;
   logic [LOC_BITS-1:0]    match_loc;
   logic [LOC_BITS-1:0]    victim_loc;
   logic [63:0]            victim_line;
   logic                   hit;

   assign old_row = row_type'(row_rd);
   assign base_loc = LOC_BITS'(LOC_BITS'(set_idx) * LOC_BITS'(WAYS));

   // Lookup and victim election.
   always_comb begin
      found       = 1'b0;
      match_way   = '0;
      any_invalid = 1'b0;
      invalid_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (!found && old_row.ways[w].tag == tag) begin
            found     = 1'b1;
            match_way = HAND_W'(w);
         end
         if (!any_invalid && old_row.ways[w].state == MESI_I) begin
            any_invalid = 1'b1;
            invalid_way = HAND_W'(w);
         end
      end

      for (int k = 0; k < WAYS; k++) begin
         ring_sum = (HAND_W + 1)'(old_row.hand) + (HAND_W + 1)'(k);
         if (ring_sum >= (HAND_W + 1)'(WAYS)) begin
            ring_sum = ring_sum - (HAND_W + 1)'(WAYS);
         end
         ring_idx[k] = HAND_W'(ring_sum);
      end

      any_free  = 1'b0;
      free_rank = '0;
      for (int k = 0; k < WAYS; k++) begin
         if (!any_free && !old_row.ways[ring_idx[k]].use_bit) begin
            any_free  = 1'b1;
            free_rank = HAND_W'(k);
         end
      end

      if (any_invalid) begin
         victim = invalid_way;
      end else if (any_free) begin
         victim = ring_idx[free_rank];
      end else begin
         victim = old_row.hand;
      end

      next_hand = (HAND_W + 1)'(victim) + (HAND_W + 1)'(1);
      if (next_hand >= (HAND_W + 1)'(WAYS)) begin
         next_hand = '0;
      end
   end

   assign line_state   = found ? old_row.ways[match_way].state : MESI_I;
   assign victim_state = old_row.ways[victim].state;
   assign match_loc    = LOC_BITS'(base_loc + LOC_BITS'(match_way));
   assign victim_loc   = LOC_BITS'(base_loc + LOC_BITS'(victim));
   assign victim_line  = 64'(old_row.ways[victim].tag) * 64'(SETS) + 64'(set_idx);
   assign hit = found && (line_state != MESI_I) &&
                !((line_state == MESI_M) && !private_level);

   // Row rewrite and result.
   always_comb begin
      new_row = old_row;
      row_we  = 1'b0;
      result  = '0;
      rank    = '0;
      unique case (cmd)
         CMD_LOAD, CMD_STORE: begin
            result.tag_found     = found;
            result.hit           = hit;
            result.line_state    = line_state;
            result.line_location = found ? LOC_W'(match_loc) : '0;
            if (hit) begin
               new_row.ways[match_way].use_bit = 1'b1;
               row_we = 1'b1;
            end
         end
         CMD_INSERT: begin
            result.tag_found     = found;
            result.line_state    = line_state;
            result.line_location = LOC_W'(victim_loc);
            if (victim_state == MESI_M) begin
               result.victim_action = private_level ? VACT_WRITE_BACK : VACT_WRITE_THROUGH;
            end
            if (victim_state != MESI_I) begin
               result.evict_addr = ADDR_W'(victim_line * 64'(LINE_BYTES));
            end
            if (!any_invalid) begin
               // The sweep clears the use bit of every way it passes over.
               for (int w = 0; w < WAYS; w++) begin
                  if (HAND_W'(w) >= old_row.hand) begin
                     rank = (HAND_W + 1)'(w) - (HAND_W + 1)'(old_row.hand);
                  end else begin
                     rank = (HAND_W + 1)'(w) + (HAND_W + 1)'(WAYS) -
                            (HAND_W + 1)'(old_row.hand);
                  end
                  if (!any_free || rank < (HAND_W + 1)'(free_rank)) begin
                     new_row.ways[w].use_bit = 1'b0;
                  end
               end
               new_row.hand = HAND_W'(next_hand);
            end
            new_row.ways[victim].tag     = tag;
            new_row.ways[victim].state   = new_state;
            new_row.ways[victim].use_bit = 1'b1;
            row_we = 1'b1;
         end
         CMD_UPDATE: begin
            result.tag_found     = found;
            result.line_state    = line_state;
            result.line_location = found ? LOC_W'(match_loc) : '0;
            result.update_missed = !found;
            if (found) begin
               new_row.ways[match_way].state = new_state;
               row_we = 1'b1;
            end
         end
         CMD_PROBE: begin
            result.tag_found     = found;
            result.line_state    = line_state;
            result.line_location = found ? LOC_W'(match_loc) : '0;
         end
         default: begin
            result = '0;
         end
      endcase
   end

   assign row_wr = ROW_BITS'(new_row);

endmodule
